@@ rtl/kta_pkg.sv @@
// shared types, widths and codes of the keyed traffic accumulator table
package kta_pkg;

    localparam int SLOTS_DEF   = 16;
    localparam int BUCKETS_DEF = 256;
    localparam int WAYS_DEF    = 4;

    localparam int KEY_W  = 32;
    localparam int TRAF_W = 32;
    localparam int TOT_W  = 64;
    localparam int IDX_W  = 14;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;
    localparam int BC_W   = 9;

    localparam logic [BC_W-1:0] BC_RESET = 9'd256;

    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 128;

    localparam int REM_DIVIDEND_W = 32;
    localparam int REM_BITS       = 4;
    localparam int REM_STEPS      = REM_DIVIDEND_W / REM_BITS;
    localparam int REM_CNT_W      = $clog2(REM_STEPS);

    typedef enum logic [CMD_W-1:0] {
        CMD_ACC   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_BIZ_FULL = 2'd1,
        ST_BKT_FULL = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [KEY_W-1:0]  biz;
        logic [KEY_W-1:0]  usr;
        logic [TRAF_W-1:0] traffic;
        logic [IDX_W-1:0]  idx;
    } req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } rem_stat_t;

endpackage

@@ rtl/kta_front.sv @@
// front end: request intake, command classification and two-entry request queue
module kta_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [kta_pkg::IN_DATA_W-1:0] s_tdata,  // biz key, user_id, traffic, entry_index
    input  logic [kta_pkg::CMD_W-1:0]     s_tuser,  // cmd
    input  logic                          pop,
    output logic                          q_valid,
    output kta_pkg::req_t                 q_req
);
    import kta_pkg::*;

    req_t       fifo_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       do_pop;
    req_t       in_req;

    always_comb
    begin
        in_req.cmd     = cmd_t'(s_tuser);
        in_req.biz     = s_tdata[31:0];
        in_req.usr     = s_tdata[63:32];
        in_req.traffic = s_tdata[95:64];
        in_req.idx     = s_tdata[109:96];
    end

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign do_pop   = pop && q_valid;
    assign q_req    = fifo_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= in_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, do_pop};
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("request queue count out of range");

    a_full_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2 && !do_pop) |=> count_reg == 2'd2)
        else $error("full request queue lost an entry");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd1 && do_pop && !push) |=> count_reg == 2'd0)
        else $error("request queue count slipped");

endmodule

@@ rtl/kta_rem.sv @@
// iterative remainder unit, four dividend bits per cycle
module kta_rem
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [kta_pkg::REM_DIVIDEND_W-1:0] dividend,
    input  logic [kta_pkg::BC_W-1:0]           divisor,
    output kta_pkg::rem_stat_t                 stat,
    output logic [kta_pkg::BC_W-1:0]           rem
);
    import kta_pkg::*;

    logic [REM_DIVIDEND_W-1:0] q_reg;
    logic [REM_DIVIDEND_W-1:0] q_next;
    logic [BC_W-1:0]           r_reg;
    logic [BC_W-1:0]           r_next;
    logic [BC_W-1:0]           d_reg;
    logic [REM_CNT_W-1:0]      cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;

    always_comb
    begin
        logic [BC_W:0] t;
        q_next = q_reg;
        r_next = r_reg;
        t      = '0;
        for (int k = 0; k < REM_BITS; k++)
        begin
            t      = {r_next, q_next[REM_DIVIDEND_W-1]};
            q_next = {q_next[REM_DIVIDEND_W-2:0], 1'b0};
            if (t >= {1'b0, d_reg})
            begin
                t         = t - {1'b0, d_reg};
                q_next[0] = 1'b1;
            end
            r_next = t[BC_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == REM_CNT_W'(REM_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign rem       = r_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("remainder unit restarted while busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("remainder done without a run");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("remainder done while still busy");

endmodule

@@ rtl/kta_back.sv @@
// back end: business slots, record memory, read-modify-write sequencer and result register
module kta_back #(
    parameter int SLOTS   = kta_pkg::SLOTS_DEF,
    parameter int BUCKETS = kta_pkg::BUCKETS_DEF,
    parameter int WAYS    = kta_pkg::WAYS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [kta_pkg::BC_W-1:0]       cfg_data,
    input  logic                           q_valid,
    input  kta_pkg::req_t                  q_req,
    output logic                           pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [kta_pkg::OUT_DATA_W-1:0] m_tdata,  // biz key out, user_id_out, traffic_total
    output logic [kta_pkg::STAT_W-1:0]     m_tuser   // status
);
    import kta_pkg::*;

    localparam int ROWS    = SLOTS * BUCKETS;
    localparam int RECORDS = ROWS * WAYS;
    localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;

    localparam int RECIP_SH = 20;
    localparam int RECIP_M  = ((1 << RECIP_SH) + WAYS - 1) / WAYS;
    localparam int PROD_W   = IDX_W + RECIP_SH + 1;

    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  user;
        logic [TOT_W-1:0]  total;
    } rec_t;

    typedef struct packed {
        logic [SLOT_W-1:0]     slot;
        rec_t [WAYS-1:0]       way;
    } row_t;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_DIV,
        S_UPD,
        S_EMIT
    } state_t;

    state_t                state_reg;
    row_t                  mem [ROWS];
    row_t                  rdata_reg;
    req_t                  req_reg;
    logic [BC_W-1:0]       bc_reg;
    logic [ROW_W-1:0]      row_reg;
    logic [ROW_W-1:0]      sweep_cnt_reg;
    logic [WAY_W-1:0]      way_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic                  sweep_after_reg;
    logic [SLOTS-1:0]      biz_valid_reg;
    logic [KEY_W-1:0]      biz_key_reg [SLOTS];
    status_t               res_status_reg;
    logic [KEY_W-1:0]      res_biz_reg;
    logic [KEY_W-1:0]      res_usr_reg;
    logic [TOT_W-1:0]      res_tot_reg;
    logic                  out_valid_reg;
    status_t               out_status_reg;
    logic [KEY_W-1:0]      out_biz_reg;
    logic [KEY_W-1:0]      out_usr_reg;
    logic [TOT_W-1:0]      out_tot_reg;

    logic                  rem_start;
    logic [REM_DIVIDEND_W-1:0] rem_dividend;
    logic [BC_W-1:0]       rem_divisor;
    rem_stat_t             rem_st;
    logic [BC_W-1:0]       rem_rem;
    logic [BC_W-1:0]       div_eff;

    logic [PROD_W-1:0]     rd_prod;
    logic [IDX_W-1:0]      rd_quot;
    logic [IDX_W-1:0]      rd_rest;
    logic [ROW_W-1:0]      rd_row;
    logic [WAY_W-1:0]      rd_way;

    logic                  match_found;
    logic [SLOT_W-1:0]     match_slot;
    logic                  free_found;
    logic [SLOT_W-1:0]     free_slot;
    logic [SLOT_W-1:0]     slot_sel;
    logic                  no_slot;
    logic [ROW_W-1:0]      row_calc;
    logic                  in_range;

    logic                  hit;
    logic [WAY_W-1:0]      hit_way;
    logic                  free_way_found;
    logic [WAY_W-1:0]      free_way;
    logic [TOT_W-1:0]      sum;
    row_t                  row_upd;
    rec_t                  rd_rec;

    logic                  mem_re;
    logic [ROW_W-1:0]      mem_raddr;
    logic                  mem_we;
    logic [ROW_W-1:0]      mem_waddr;
    row_t                  mem_wdata;
    logic                  out_load;

    assign cfg_ready = 1'b1;

    // effective bucket divisor
    always_comb
    begin
        if (bc_reg == '0)
        begin
            div_eff = BC_W'(1);
        end
        else if (32'(bc_reg) > 32'(BUCKETS))
        begin
            div_eff = BC_W'(BUCKETS);
        end
        else
        begin
            div_eff = bc_reg;
        end
    end

    assign pop          = (state_reg == S_IDLE) && q_valid;
    assign rem_start    = pop && (q_req.cmd == CMD_ACC);
    assign rem_dividend = q_req.usr;
    assign rem_divisor  = div_eff;

    kta_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (rem_dividend),
        .divisor  (rem_divisor),
        .stat     (rem_st),
        .rem      (rem_rem)
    );

    // row and way of a read index by reciprocal multiplication
    assign rd_prod = PROD_W'(req_reg.idx) * PROD_W'(RECIP_M);
    assign rd_quot = IDX_W'(rd_prod >> RECIP_SH);
    assign rd_rest = req_reg.idx - IDX_W'(32'(rd_quot) * 32'(WAYS));
    assign rd_row  = ROW_W'(rd_quot);
    assign rd_way  = WAY_W'(rd_rest);

    // business slot lookup
    always_comb
    begin
        match_found = 1'b0;
        match_slot  = '0;
        free_found  = 1'b0;
        free_slot   = '0;
        for (int s = 0; s < SLOTS; s++)
        begin
            if (biz_valid_reg[s])
            begin
                if (!match_found && biz_key_reg[s] == req_reg.biz)
                begin
                    match_found = 1'b1;
                    match_slot  = SLOT_W'(s);
                end
            end
            else if (!free_found)
            begin
                free_found = 1'b1;
                free_slot  = SLOT_W'(s);
            end
        end
    end

    assign slot_sel = match_found ? match_slot : free_slot;
    assign no_slot  = !match_found && !free_found;
    assign row_calc = ROW_W'(32'(slot_sel) * 32'(BUCKETS) + 32'(rem_rem));
    assign in_range = 32'(req_reg.idx) < 32'(RECORDS);

    // way lookup on the fetched row
    always_comb
    begin
        hit            = 1'b0;
        hit_way        = '0;
        free_way_found = 1'b0;
        free_way       = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (rdata_reg.way[w].valid)
            begin
                if (!hit && rdata_reg.way[w].user == req_reg.usr)
                begin
                    hit     = 1'b1;
                    hit_way = WAY_W'(w);
                end
            end
            else if (!free_way_found)
            begin
                free_way_found = 1'b1;
                free_way       = WAY_W'(w);
            end
        end
    end

    assign sum    = rdata_reg.way[hit_way].total + TOT_W'(req_reg.traffic);
    assign rd_rec = rdata_reg.way[way_reg];

    always_comb
    begin
        row_upd      = rdata_reg;
        row_upd.slot = slot_reg;
        if (hit)
        begin
            row_upd.way[hit_way].total = sum;
        end
        else
        begin
            row_upd.way[free_way].valid = 1'b1;
            row_upd.way[free_way].user  = req_reg.usr;
            row_upd.way[free_way].total = TOT_W'(req_reg.traffic);
        end
    end

    assign mem_re    = (state_reg == S_DIV)
                       && ((req_reg.cmd == CMD_ACC && rem_st.done && !no_slot)
                           || (req_reg.cmd == CMD_READ && in_range));
    assign mem_raddr = (req_reg.cmd == CMD_ACC) ? row_calc : rd_row;
    assign mem_we    = (state_reg == S_SWEEP)
                       || ((state_reg == S_UPD) && req_reg.cmd == CMD_ACC
                           && (hit || free_way_found));
    assign mem_waddr = (state_reg == S_SWEEP) ? sweep_cnt_reg : row_reg;
    assign mem_wdata = (state_reg == S_SWEEP) ? row_t'('0) : row_upd;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    assign out_load = (state_reg == S_EMIT) && (!out_valid_reg || m_tready);

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            req_reg <= q_req;
        end
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_biz_reg    <= res_biz_reg;
            out_usr_reg    <= res_usr_reg;
            out_tot_reg    <= res_tot_reg;
        end
        if (state_reg == S_DIV && rem_st.done && req_reg.cmd == CMD_ACC
            && !no_slot && !match_found)
        begin
            biz_key_reg[free_slot] <= req_reg.biz;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_SWEEP;
            sweep_cnt_reg   <= '0;
            sweep_after_reg <= 1'b0;
            biz_valid_reg   <= '0;
            bc_reg          <= BC_RESET;
            out_valid_reg   <= 1'b0;
            row_reg         <= '0;
            way_reg         <= '0;
            slot_reg        <= '0;
            res_status_reg  <= ST_OK;
            res_biz_reg     <= '0;
            res_usr_reg     <= '0;
            res_tot_reg     <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                bc_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_SWEEP:
                begin
                    if (sweep_cnt_reg == ROW_W'(ROWS - 1))
                    begin
                        sweep_cnt_reg <= '0;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        sweep_cnt_reg <= sweep_cnt_reg + 1'b1;
                    end
                end
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        res_status_reg <= ST_OK;
                        res_biz_reg    <= '0;
                        res_usr_reg    <= '0;
                        res_tot_reg    <= '0;
                        unique case (q_req.cmd)
                            CMD_ACC, CMD_READ:
                            begin
                                state_reg <= S_DIV;
                            end
                            CMD_CLEAR:
                            begin
                                biz_valid_reg   <= '0;
                                sweep_after_reg <= 1'b1;
                                state_reg       <= S_EMIT;
                            end
                            default:
                            begin
                                state_reg <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_DIV:
                begin
                    if (req_reg.cmd == CMD_ACC)
                    begin
                        if (rem_st.done)
                        begin
                            if (no_slot)
                            begin
                                res_status_reg <= ST_BIZ_FULL;
                                res_biz_reg    <= req_reg.biz;
                                res_usr_reg    <= req_reg.usr;
                                state_reg      <= S_EMIT;
                            end
                            else
                            begin
                                if (!match_found)
                                begin
                                    biz_valid_reg[free_slot] <= 1'b1;
                                end
                                slot_reg  <= slot_sel;
                                row_reg   <= row_calc;
                                state_reg <= S_UPD;
                            end
                        end
                    end
                    else if (in_range)
                    begin
                        row_reg   <= rd_row;
                        way_reg   <= rd_way;
                        state_reg <= S_UPD;
                    end
                    else
                    begin
                        res_status_reg <= ST_EMPTY;
                        state_reg      <= S_EMIT;
                    end
                end
                S_UPD:
                begin
                    if (req_reg.cmd == CMD_ACC)
                    begin
                        res_biz_reg <= req_reg.biz;
                        res_usr_reg <= req_reg.usr;
                        if (hit)
                        begin
                            res_status_reg <= ST_OK;
                            res_tot_reg    <= sum;
                        end
                        else if (free_way_found)
                        begin
                            res_status_reg <= ST_OK;
                            res_tot_reg    <= TOT_W'(req_reg.traffic);
                        end
                        else
                        begin
                            res_status_reg <= ST_BKT_FULL;
                            res_tot_reg    <= '0;
                        end
                    end
                    else if (rd_rec.valid)
                    begin
                        res_status_reg <= ST_OK;
                        res_biz_reg    <= biz_key_reg[rdata_reg.slot];
                        res_usr_reg    <= rd_rec.user;
                        res_tot_reg    <= rd_rec.total;
                    end
                    else
                    begin
                        res_status_reg <= ST_EMPTY;
                    end
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_load)
                    begin
                        if (sweep_after_reg)
                        begin
                            sweep_after_reg <= 1'b0;
                            state_reg       <= S_SWEEP;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {out_tot_reg, out_usr_reg, out_biz_reg};

    a_no_pop_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWEEP) |-> !pop)
        else $error("request taken during table sweep");

    a_emit_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_valid_reg && !m_tready) |=> state_reg == S_EMIT)
        else $error("result dropped while output register full");

    a_write_only_acc: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && state_reg != S_SWEEP) |-> req_reg.cmd == CMD_ACC)
        else $error("record memory written by a non-accumulate request");

endmodule

@@ rtl/keyed_traffic_accumulator_table.sv @@
// top level of the keyed traffic accumulator table
// accumulate requests go from intake to result in these steps: dequeue, the
// 4-bit-per-cycle remainder unit, record row read, update/write, emit; reads skip the remainder unit
// clear is dequeued and emitted, then sweeps all SLOTS*BUCKETS rows (4096 by default)
// one request is worked on at a time; the queue holds two
// reset (rst_n low, async) clears control state, sets bucket_count to 256 and starts
// a sweep of all SLOTS*BUCKETS record memory rows before any request is worked on
module keyed_traffic_accumulator_table #(
    parameter int SLOTS   = kta_pkg::SLOTS_DEF,
    parameter int BUCKETS = kta_pkg::BUCKETS_DEF,
    parameter int WAYS    = kta_pkg::WAYS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [kta_pkg::BC_W-1:0]       cfg_data,   // bucket_count
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [kta_pkg::IN_DATA_W-1:0]  s_tdata,    // biz key, user_id, traffic, entry_index
    input  logic [kta_pkg::CMD_W-1:0]      s_tuser,    // cmd
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [kta_pkg::OUT_DATA_W-1:0] m_tdata,    // biz key out, user_id_out, traffic_total
    output logic [kta_pkg::STAT_W-1:0]     m_tuser     // status
);
    import kta_pkg::*;

    logic q_valid;
    logic pop;
    req_t q_req;

    kta_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_req    (q_req)
    );

    kta_back #(
        .SLOTS   (SLOTS),
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_req     (q_req),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

@@ tb/sv/testbench.sv @@
// self-checking testbench of the keyed traffic accumulator table
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import kta_pkg::*;

    localparam int SLOTS   = SLOTS_DEF;
    localparam int BUCKETS = BUCKETS_DEF;
    localparam int WAYS    = WAYS_DEF;
    localparam int RECORDS = SLOTS * BUCKETS * WAYS;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        status_t          status;
        logic [KEY_W-1:0] biz;
        logic [KEY_W-1:0] usr;
        logic [TOT_W-1:0] total;
    } outcome_t;

    typedef enum int { IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH } idle_mode_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [BC_W-1:0]       cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [CMD_W-1:0]      s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STAT_W-1:0]     m_tuser;

    req_t       pending_requests[$];
    req_t       req_on_bus;
    outcome_t   expected_outcomes[$];
    idle_mode_t idle_mode;
    int         error_count;
    longint     cycle_count;

    logic [BC_W-1:0]  bucket_count;
    bit               biz_valid[SLOTS];
    logic [KEY_W-1:0] biz_key[SLOTS];
    bit               rec_valid[RECORDS];
    logic [KEY_W-1:0] rec_user[RECORDS];
    logic [TOT_W-1:0] rec_total[RECORDS];

    keyed_traffic_accumulator_table uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int divisor_in_use();
        if (bucket_count == 0)
            return 1;
        if (bucket_count > BUCKETS)
            return BUCKETS;
        return int'(bucket_count);
    endfunction

    function automatic void clear_table();
        biz_valid = '{default: 0};
        rec_valid = '{default: 0};
    endfunction

    function automatic outcome_t account_request(req_t r);
        outcome_t o;
        int slot;
        int free_slot;
        int hit;
        int free_way;
        int base;
        o = '{ST_OK, '0, '0, '0};
        case (r.cmd)
            CMD_ACC:
            begin
                slot = -1;
                free_slot = -1;
                for (int s = 0; s < SLOTS; s++)
                begin
                    if (biz_valid[s])
                    begin
                        if (slot < 0 && biz_key[s] == r.biz)
                            slot = s;
                    end
                    else if (free_slot < 0)
                        free_slot = s;
                end
                o.biz = r.biz;
                o.usr = r.usr;
                if (slot < 0 && free_slot < 0)
                begin
                    o.status = ST_BIZ_FULL;
                    return o;
                end
                if (slot < 0)
                begin
                    slot = free_slot;
                    biz_valid[slot] = 1;
                    biz_key[slot] = r.biz;
                end
                base = (slot * BUCKETS + int'(r.usr % divisor_in_use())) * WAYS;
                hit = -1;
                free_way = -1;
                for (int w = 0; w < WAYS; w++)
                begin
                    if (rec_valid[base + w])
                    begin
                        if (hit < 0 && rec_user[base + w] == r.usr)
                            hit = w;
                    end
                    else if (free_way < 0)
                        free_way = w;
                end
                if (hit >= 0)
                begin
                    rec_total[base + hit] += TOT_W'(r.traffic);
                    o.total = rec_total[base + hit];
                end
                else if (free_way < 0)
                    o.status = ST_BKT_FULL;
                else
                begin
                    rec_valid[base + free_way] = 1;
                    rec_user[base + free_way] = r.usr;
                    rec_total[base + free_way] = TOT_W'(r.traffic);
                    o.total = TOT_W'(r.traffic);
                end
            end
            CMD_READ:
            begin
                if (rec_valid[r.idx])
                begin
                    o.biz = biz_key[r.idx / (BUCKETS * WAYS)];
                    o.usr = rec_user[r.idx];
                    o.total = rec_total[r.idx];
                end
                else
                    o.status = ST_EMPTY;
            end
            CMD_CLEAR:
                clear_table();
            default:
                ;
        endcase
        return o;
    endfunction

    // driver: holds a request until taken, then maybe idles
    always @(posedge clk or negedge rst_n)
    begin
        bit   hold;
        bit   load;
        req_t nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= CMD_NOP;
        end
        else
        begin
            hold = s_tvalid && !s_tready;
            if (s_tvalid && s_tready)
                expected_outcomes.push_back(account_request(req_on_bus));
            load = 0;
            if (!hold && pending_requests.size() > 0)
                load = !((idle_mode == IDLE_SENDER && $urandom_range(99) < 81) ||
                         (idle_mode == IDLE_BOTH && $urandom_range(99) < 9));
            if (load)
            begin
                nxt = pending_requests.pop_front();
                req_on_bus = nxt;
                s_tdata <= {2'b00, nxt.idx, nxt.traffic, nxt.usr, nxt.biz};
                s_tuser <= nxt.cmd;
            end
            s_tvalid <= hold || load;
        end
    end

    // monitor: random back-pressure and comparison against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        outcome_t e;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    $display("%0t: unexpected result status %0d data %h",
                             $time, m_tuser, m_tdata);
                    error_count++;
                end
                else
                begin
                    e = expected_outcomes.pop_front();
                    if (m_tuser !== e.status || m_tdata[31:0] !== e.biz ||
                        m_tdata[63:32] !== e.usr || m_tdata[127:64] !== e.total)
                    begin
                        $display("%0t: mismatch expected st=%0d biz=%h usr=%h tot=%h",
                                 $time, e.status, e.biz, e.usr, e.total);
                        $display("%0t:          actual   st=%0d biz=%h usr=%h tot=%h",
                                 $time, m_tuser, m_tdata[31:0], m_tdata[63:32],
                                 m_tdata[127:64]);
                        error_count++;
                    end
                end
            end
            if (idle_mode == IDLE_RECEIVER)
                m_tready <= $urandom_range(99) >= 81;
            else if (idle_mode == IDLE_BOTH)
                m_tready <= $urandom_range(99) >= 9;
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic req_t make_request(cmd_t c, logic [31:0] b, logic [31:0] u,
                                          logic [31:0] t, logic [13:0] i);
        req_t r;
        r.cmd = c;
        r.biz = b;
        r.usr = u;
        r.traffic = t;
        r.idx = i;
        return r;
    endfunction

    // mostly keys from small pools so slots and buckets fill up
    function automatic req_t random_request();
        int roll;
        int div;
        logic [31:0] b;
        logic [31:0] u;
        logic [13:0] i;
        roll = $urandom_range(99);
        div = divisor_in_use();
        b = ($urandom_range(9) < 8) ? 32'h1000_0001 * $urandom_range(19) : $urandom;
        u = ($urandom_range(9) < 7) ? $urandom_range(23) : $urandom;
        if ($urandom_range(9) < 7)
            i = 14'(($urandom_range(3) * BUCKETS + ($urandom_range(23) % div)) * WAYS
                    + $urandom_range(WAYS - 1));
        else
            i = 14'($urandom);
        if (roll < 70)
            return make_request(CMD_ACC, b, u, $urandom, i);
        if (roll < 94)
            return make_request(CMD_READ, b, u, $urandom, i);
        if (roll < 96)
            return make_request(CMD_CLEAR, $urandom, $urandom, $urandom, i);
        return make_request(CMD_NOP, $urandom, $urandom, $urandom, 14'($urandom));
    endfunction

    task automatic write_bucket_count(logic [BC_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        bucket_count = v;
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_requests();
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || s_tvalid || expected_outcomes.size() != 0);
        repeat (20) @(posedge clk);
    endtask

    initial
    begin
        logic [BC_W-1:0] settings[8] = '{9'd1, 9'd256, 9'd511, 9'd0, 9'd7, 9'd200, 9'd3,
                                         9'd256};
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        idle_mode = IDLE_NONE;
        error_count = 0;
        cycle_count = 0;
        bucket_count = BC_RESET;
        clear_table();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes at reset divisor, reads, unused command and a clear
        pending_requests.push_back(make_request(CMD_ACC, '0, '0, '0, '0));
        pending_requests.push_back(make_request(CMD_ACC, '0, '0, '1, '0));
        pending_requests.push_back(make_request(CMD_ACC, '1, '1, '1, '1));
        pending_requests.push_back(make_request(CMD_ACC, '1, '1, '1, '1));
        pending_requests.push_back(make_request(CMD_READ, '1, '1, '1, 14'd0));
        pending_requests.push_back(make_request(CMD_READ, '0, '0, '0, 14'd1023 + 14'd4));
        pending_requests.push_back(make_request(CMD_READ, '0, '0, '0, '1));
        pending_requests.push_back(make_request(CMD_NOP, '1, '1, '1, '1));
        pending_requests.push_back(make_request(CMD_CLEAR, '1, '1, '1, '1));
        pending_requests.push_back(make_request(CMD_READ, '0, '0, '0, 14'd0));
        drain_requests();

        // single bucket: bucket overflow, then business table overflow
        write_bucket_count(settings[0]);
        for (int k = 0; k < 5; k++)
            pending_requests.push_back(make_request(CMD_ACC, 32'd5, 32'd100 + k, 32'd9, '0));
        for (int k = 0; k < 17; k++)
            pending_requests.push_back(make_request(CMD_ACC, 32'hA000 + k, 32'd1, 32'd1, '0));
        pending_requests.push_back(make_request(CMD_READ, '0, '0, '0, 14'(15 * 1024)));
        drain_requests();

        for (int p = 0; p < 8; p++)
        begin
            if (p > 0)
                write_bucket_count(settings[p]);
            idle_mode = idle_mode_t'(p % 4);
            for (int k = 0; k < 65; k++)
                pending_requests.push_back(random_request());
            drain_requests();
        end

        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

@@ sim.f @@
rtl/kta_pkg.sv
rtl/kta_front.sv
rtl/kta_rem.sv
rtl/kta_back.sv
rtl/keyed_traffic_accumulator_table.sv
tb/sv/testbench.sv
